// ===== rtl/imu_serial_packet_parser_top_assert.svh =====
// Assertion macros shared by the IMU packet parser modules.
`ifndef IMU_SERIAL_PACKET_PARSER_TOP_ASSERT_SVH
`define IMU_SERIAL_PACKET_PARSER_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Checks a property at every rising clock edge outside reset.
`define IMU_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("imu parser assertion failed");
// Checks that a condition never holds outside reset.
`define IMU_ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
        else $error("imu parser forbidden condition seen");
`else
`define IMU_ASSERT(label, clk, rst_n, prop)
`define IMU_ASSERT_NEVER(label, clk, rst_n, cond)
`endif

`endif

// ===== rtl/imu_spp_pkg.sv =====
// Shared constants, types and decode function of the IMU packet parser.
package imu_spp_pkg;

    localparam int BYTE_W   = 8;
    localparam int WORD_W   = 16;
    localparam int POS_W    = 4;
    localparam int KIND_W   = 2;
    localparam int FRAME_LEN = 11;

    localparam logic [POS_W-1:0] POS_HUNT = POS_W'(0);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(FRAME_LEN - 1);

    localparam logic [BYTE_W-1:0] HEADER_BYTE = 8'h55;
    localparam logic [BYTE_W-1:0] TYPE_ACCEL  = 8'h51;
    localparam logic [BYTE_W-1:0] TYPE_GYRO   = 8'h52;
    localparam logic [BYTE_W-1:0] TYPE_ANGLE  = 8'h53;

    localparam logic [KIND_W-1:0] KIND_ACCEL = 2'd0;
    localparam logic [KIND_W-1:0] KIND_GYRO  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ANGLE = 2'd2;
    localparam logic [KIND_W-1:0] KIND_OTHER = 2'd3;

    // Highest frame byte the back end keeps: type byte and the three words.
    localparam int KEEP_LAST = 7;

    localparam int MID_DEPTH_DEF = 4;
    localparam int OUT_DEPTH_DEF = 2;

    // A kept input byte tagged with its place in the frame.
    typedef struct packed {
        logic [POS_W-1:0]  pos;
        logic [BYTE_W-1:0] data;
    } t_tagged;

    typedef struct packed {
        logic                     checksum_ok;
        logic [KIND_W-1:0]        packet_kind;
        logic signed [WORD_W-1:0] value_x;
        logic signed [WORD_W-1:0] value_y;
        logic signed [WORD_W-1:0] value_z;
    } t_result;

    function automatic logic [KIND_W-1:0] kind_of(input logic [BYTE_W-1:0] type_byte);
        logic [KIND_W-1:0] kind;
        unique case (type_byte)
            TYPE_ACCEL: kind = KIND_ACCEL;
            TYPE_GYRO:  kind = KIND_GYRO;
            TYPE_ANGLE: kind = KIND_ANGLE;
            default:    kind = KIND_OTHER;
        endcase
        return kind;
    endfunction

endpackage

// ===== rtl/imu_spp_queue.sv =====
// Small register queue used between the parser stages and at the result side.
module imu_spp_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr = r_wr;
        n_rd = r_rd;
        if (do_push) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (do_pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

`include "imu_serial_packet_parser_top_assert.svh"

    `IMU_ASSERT_NEVER(a_count_bound, i_clk, i_rst_n, r_count > CNT_W'(DEPTH))
    `IMU_ASSERT(a_count_track, i_clk, i_rst_n, (do_push && !do_pop) |=> !o_empty)

endmodule

// ===== rtl/imu_spp_front.sv =====
// Front end: hunts for the header and tags every frame byte with its position.
module imu_spp_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_accept,
    input  logic [imu_spp_pkg::BYTE_W-1:0] i_rx_byte,
    output logic                        o_push,
    output imu_spp_pkg::t_tagged        o_tagged
);
    import imu_spp_pkg::*;

    logic [POS_W-1:0] r_pos, n_pos;
    logic             keep;

    always_comb begin
        n_pos = r_pos;
        keep  = 1'b0;
        if (i_accept) begin
            if (r_pos == POS_HUNT) begin
                if (i_rx_byte == HEADER_BYTE) begin
                    keep  = 1'b1;
                    n_pos = r_pos + 1'b1;
                end
            end else if (r_pos >= POS_LAST) begin
                keep  = 1'b1;
                n_pos = POS_HUNT;
            end else begin
                keep  = 1'b1;
                n_pos = r_pos + 1'b1;
            end
        end
    end

    assign o_push        = keep;
    assign o_tagged.pos  = r_pos;
    assign o_tagged.data = i_rx_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= POS_HUNT;
        end else begin
            r_pos <= n_pos;
        end
    end

`include "imu_serial_packet_parser_top_assert.svh"

    `IMU_ASSERT_NEVER(a_pos_range, i_clk, i_rst_n, r_pos > POS_LAST)
    `IMU_ASSERT(a_hunt_drop, i_clk, i_rst_n, (i_accept && r_pos == POS_HUNT && i_rx_byte != HEADER_BYTE) |=> r_pos == POS_HUNT)

endmodule

// ===== rtl/imu_spp_back.sv =====
// Back end: collects tagged frame bytes, keeps the checksum and builds results.
module imu_spp_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  imu_spp_pkg::t_tagged i_tagged,
    output logic                 o_pop,
    input  logic                 i_res_full,
    output logic                 o_res_push,
    output imu_spp_pkg::t_result o_result
);
    import imu_spp_pkg::*;

    logic [BYTE_W-1:0] r_bytes [1:KEEP_LAST];
    logic [BYTE_W-1:0] r_sum;
    logic              is_last;

    assign is_last    = (i_tagged.pos == POS_LAST);
    // The closing byte waits until the result queue has room.
    assign o_pop      = i_valid && !(is_last && i_res_full);
    assign o_res_push = o_pop && is_last;

    assign o_result.checksum_ok = (r_sum == i_tagged.data);
    assign o_result.packet_kind = kind_of(r_bytes[1]);
    assign o_result.value_x     = {r_bytes[3], r_bytes[2]};
    assign o_result.value_y     = {r_bytes[5], r_bytes[4]};
    assign o_result.value_z     = {r_bytes[7], r_bytes[6]};

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            if (i_tagged.pos == POS_HUNT) begin
                r_sum <= i_tagged.data;
            end else begin
                r_sum <= r_sum + i_tagged.data;
            end
            for (int i = 1; i <= KEEP_LAST; i++) begin
                if (i_tagged.pos == POS_W'(i)) begin
                    r_bytes[i] <= i_tagged.data;
                end
            end
        end
    end

`include "imu_serial_packet_parser_top_assert.svh"

    `IMU_ASSERT(a_frame_starts_with_header, i_clk, i_rst_n, (o_pop && i_tagged.pos == POS_HUNT) |-> (i_tagged.data == HEADER_BYTE))

endmodule

// ===== rtl/imu_serial_packet_parser_top.sv =====
// Top level of the IMU 11-byte serial packet parser.
// This block takes one received serial byte per item and turns each 11-byte frame into one
// result. While hunting it drops every byte other than the header 0x55; after a header it
// takes ten more bytes as data, whatever their values, so a header byte inside a frame does
// not restart it. Each completed frame gives one result item with the checksum flag (byte 10
// against the low 8 bits of the sum of bytes 0 to 9), the kind (0 accel for type 0x51, 1 gyro
// for 0x52, 2 angle for 0x53, 3 any other type) and the first three little-endian signed words
// as raw counts; the temperature word is dropped and results with a bad checksum are still
// delivered. The block takes one byte every clock cycle while full is low. A front end tags
// bytes with their frame position in the cycle they arrive, a queue of MID_DEPTH entries lets
// the back end fall behind, and the back end handles one tagged byte per cycle, writing a result
// into a result queue of OUT_DEPTH entries, but holds a closing byte while that queue is full.
// full rises only when the middle queue fills, which happens only while results wait for pop
// with the result queue full. There are no configuration registers.
module imu_serial_packet_parser_top #(
    parameter int MID_DEPTH = imu_spp_pkg::MID_DEPTH_DEF,
    parameter int OUT_DEPTH = imu_spp_pkg::OUT_DEPTH_DEF
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     push,
    output logic                                     full,
    input  logic [imu_spp_pkg::BYTE_W-1:0]           i_rx_byte,
    output logic                                     empty,
    input  logic                                     pop,
    output logic                                     o_checksum_ok,
    output logic [imu_spp_pkg::KIND_W-1:0]           o_packet_kind,
    output logic signed [imu_spp_pkg::WORD_W-1:0]    o_value_x,
    output logic signed [imu_spp_pkg::WORD_W-1:0]    o_value_y,
    output logic signed [imu_spp_pkg::WORD_W-1:0]    o_value_z
);
    import imu_spp_pkg::*;

    // Front end side: an input item is taken whenever the middle queue has room.
    logic    accept;
    logic    front_push;
    t_tagged front_tagged;

    // Middle queue output toward the back end.
    logic    mid_empty;
    logic    back_pop;
    t_tagged mid_tagged;

    // Result queue input from the back end.
    logic    res_push;
    logic    res_full;
    t_result back_result;
    t_result head_result;

    assign accept = push && !full;

    imu_spp_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_rx_byte (i_rx_byte),
        .o_push    (front_push),
        .o_tagged  (front_tagged)
    );

    imu_spp_queue #(
        .WIDTH ($bits(t_tagged)),
        .DEPTH (MID_DEPTH)
    ) u_mid_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_data  (front_tagged),
        .o_full  (full),
        .i_pop   (back_pop),
        .o_data  (mid_tagged),
        .o_empty (mid_empty)
    );

    imu_spp_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (!mid_empty),
        .i_tagged   (mid_tagged),
        .o_pop      (back_pop),
        .i_res_full (res_full),
        .o_res_push (res_push),
        .o_result   (back_result)
    );

    imu_spp_queue #(
        .WIDTH ($bits(t_result)),
        .DEPTH (OUT_DEPTH)
    ) u_res_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (back_result),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (head_result),
        .o_empty (empty)
    );

    assign o_checksum_ok = head_result.checksum_ok;
    assign o_packet_kind = head_result.packet_kind;
    assign o_value_x     = head_result.value_x;
    assign o_value_y     = head_result.value_y;
    assign o_value_z     = head_result.value_z;

endmodule

// ===== tb/imu_serial_packet_parser_checker.sv =====
`timescale 1ns / 1ps
// Frame predictor and result comparator for the IMU serial packet parser testbench.
module imu_serial_packet_parser_checker (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_push,
    input  logic                                  i_full,
    input  logic [imu_spp_pkg::BYTE_W-1:0]        i_rx_byte,
    input  logic                                  i_empty,
    input  logic                                  i_pop,
    input  logic                                  i_checksum_ok,
    input  logic [imu_spp_pkg::KIND_W-1:0]        i_packet_kind,
    input  logic signed [imu_spp_pkg::WORD_W-1:0] i_value_x,
    input  logic signed [imu_spp_pkg::WORD_W-1:0] i_value_y,
    input  logic signed [imu_spp_pkg::WORD_W-1:0] i_value_z,
    output int                                    o_fail_count,
    output int                                    o_outstanding,
    output int                                    o_checked
);
    import imu_spp_pkg::*;

    logic [POS_W-1:0]  frame_pos;
    logic [BYTE_W-1:0] frame_sum;
    logic [BYTE_W-1:0] frame_bytes [0:FRAME_LEN-2];
    t_result           decoded_frames [$];
    int                mismatches;
    int                checked;

    function automatic logic [KIND_W-1:0] kind_for_type(input logic [BYTE_W-1:0] type_byte);
        if (type_byte == TYPE_ACCEL) return KIND_ACCEL;
        if (type_byte == TYPE_GYRO) return KIND_GYRO;
        if (type_byte == TYPE_ANGLE) return KIND_ANGLE;
        return KIND_OTHER;
    endfunction

    // Advances the frame tracker by one received byte and queues the decoded frame
    // when the checksum byte closes it.
    task automatic track_byte(input logic [BYTE_W-1:0] rx);
        t_result frame;
        if (frame_pos == POS_HUNT) begin
            if (rx == HEADER_BYTE) begin
                frame_bytes[0] = rx;
                frame_sum = rx;
                frame_pos = POS_W'(1);
            end
        end else if (frame_pos != POS_LAST) begin
            frame_bytes[frame_pos] = rx;
            frame_sum = frame_sum + rx;
            frame_pos = frame_pos + POS_W'(1);
        end else begin
            frame.checksum_ok = (frame_sum == rx);
            frame.packet_kind = kind_for_type(frame_bytes[1]);
            frame.value_x = {frame_bytes[3], frame_bytes[2]};
            frame.value_y = {frame_bytes[5], frame_bytes[4]};
            frame.value_z = {frame_bytes[7], frame_bytes[6]};
            decoded_frames.push_back(frame);
            frame_pos = POS_HUNT;
            frame_sum = '0;
        end
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            frame_pos = POS_HUNT;
            frame_sum = '0;
            decoded_frames.delete();
            mismatches = 0;
            checked = 0;
        end else begin
            // The result side is checked first so a result never meets an expectation
            // queued at the same edge.
            if (i_pop && !i_empty) begin
                if (decoded_frames.size() == 0) begin
                    $error("result item popped while no frame was outstanding");
                    mismatches++;
                end else begin
                    t_result want;
                    want = decoded_frames.pop_front();
                    check_field("checksum_ok", int'(want.checksum_ok), int'(i_checksum_ok));
                    check_field("packet_kind", int'(want.packet_kind), int'(i_packet_kind));
                    check_field("value_x", int'(want.value_x), int'(i_value_x));
                    check_field("value_y", int'(want.value_y), int'(i_value_y));
                    check_field("value_z", int'(want.value_z), int'(i_value_z));
                    checked++;
                end
            end
            if (i_push && !i_full) begin
                track_byte(i_rx_byte);
            end
        end
        o_fail_count  <= mismatches;
        o_outstanding <= decoded_frames.size();
        o_checked     <= checked;
    end

endmodule

// ===== tb/imu_serial_packet_parser_top_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for the IMU serial packet parser: stimulus, flow control, watchdog, verdict.
module imu_serial_packet_parser_top_tb;
    import imu_spp_pkg::*;

    localparam int HALF_PERIOD  = 2;
    localparam int RESET_CYCLES = 7;
    // Cycles with no item moving on either side before the run is declared hung. The
    // longest correct stall is the receiver hold-off below, far shorter than this.
    localparam int STALL_LIMIT  = 2000;
    // Long enough for the result queue and the middle queue to fill and raise full.
    localparam int HOLD_CYCLES  = 120;
    // A result passes the middle and result queues after its closing byte; this leaves a safe margin.
    localparam int DRAIN_CYCLES = 10;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n;
    logic                     push;
    logic                     full;
    logic [BYTE_W-1:0]        i_rx_byte;
    logic                     empty;
    logic                     pop;
    logic                     o_checksum_ok;
    logic [KIND_W-1:0]        o_packet_kind;
    logic signed [WORD_W-1:0] o_value_x;
    logic signed [WORD_W-1:0] o_value_y;
    logic signed [WORD_W-1:0] o_value_z;

    int fail_count;
    int outstanding;
    int results_checked;
    int frames_sent;
    int bytes_sent;
    int idle_cycles;

    // Flow control knobs of the sender and the receiver processes.
    bit send_gaps;
    bit recv_gaps;
    bit hold_req;
    bit hold_done;

    imu_serial_packet_parser_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_rx_byte     (i_rx_byte),
        .empty         (empty),
        .pop           (pop),
        .o_checksum_ok (o_checksum_ok),
        .o_packet_kind (o_packet_kind),
        .o_value_x     (o_value_x),
        .o_value_y     (o_value_y),
        .o_value_z     (o_value_z)
    );

    imu_serial_packet_parser_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .i_full        (full),
        .i_rx_byte     (i_rx_byte),
        .i_empty       (empty),
        .i_pop         (pop),
        .i_checksum_ok (o_checksum_ok),
        .i_packet_kind (o_packet_kind),
        .i_value_x     (o_value_x),
        .i_value_y     (o_value_y),
        .i_value_z     (o_value_z),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding),
        .o_checked     (results_checked)
    );

    always begin
        #(HALF_PERIOD) i_clk = 1'b1;
        #(HALF_PERIOD) i_clk = 1'b0;
    end

    // The watchdog restarts whenever an item moves on either side of the block.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            idle_cycles <= 0;
        end else if ((push && !full) || (pop && !empty)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("Timeout: no item moved for %0d cycles", STALL_LIMIT);
            $display("Some tests failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // The receiver pops at every falling edge unless it is idling. One long hold-off is
    // taken when the main process asks for it, so the block backs up and stalls its input.
    initial begin
        pop = 1'b0;
        hold_done = 1'b0;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_req && !hold_done) begin
                pop <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                hold_done = 1'b1;
            end else if (recv_gaps && $urandom_range(0, 3) == 0) begin
                pop <= 1'b0;
                repeat ($urandom_range(1, 10) - 1) @(negedge i_clk);
            end else begin
                pop <= 1'b1;
            end
        end
    end

    // Offers one byte from a falling edge and returns at the falling edge after it is
    // taken, optionally after a burst of idle cycles. push is written once per edge.
    task automatic send_byte(input logic [BYTE_W-1:0] value);
        push <= 1'b1;
        i_rx_byte <= value;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        @(negedge i_clk);
        bytes_sent++;
        if (send_gaps && $urandom_range(0, 4) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge i_clk);
        end
    endtask

    // Sends header, type, the four little-endian words packed as {temp, z, y, x} and the
    // checksum, which is spoiled by a nonzero offset when corrupt is set.
    task automatic send_frame(input logic [BYTE_W-1:0] type_byte, input logic [63:0] words,
                              input bit corrupt);
        logic [BYTE_W-1:0] sum;
        int                i;
        sum = HEADER_BYTE + type_byte;
        for (i = 0; i < 8; i++) sum = sum + words[8*i +: 8];
        if (corrupt) sum = sum + BYTE_W'($urandom_range(1, 255));
        send_byte(HEADER_BYTE);
        send_byte(type_byte);
        for (i = 0; i < 8; i++) send_byte(words[8*i +: 8]);
        send_byte(sum);
        frames_sent++;
    endtask

    // Any byte but the header, so it is dropped while the block hunts.
    function automatic logic [BYTE_W-1:0] noise_byte();
        logic [BYTE_W-1:0] b;
        b = BYTE_W'($urandom);
        if (b == HEADER_BYTE) b = ~b;
        return b;
    endfunction

    // Word values lean toward the signed extremes.
    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(0, 7))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            default: return WORD_W'($urandom);
        endcase
    endfunction

    // Mostly well-formed frames with random content. Some are preceded by noise, a few
    // by a truncated frame that swallows the next header as data, some carry a header
    // byte in their payload, and about one in five has a bad checksum.
    task automatic random_frame();
        logic [BYTE_W-1:0] type_byte;
        logic [63:0]       words;
        int                slot;
        if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 3)) send_byte(noise_byte());
        end
        if ($urandom_range(0, 15) == 0) begin
            send_byte(HEADER_BYTE);
            repeat ($urandom_range(1, 9)) send_byte(BYTE_W'($urandom));
        end
        case ($urandom_range(0, 7))
            0, 1:    type_byte = TYPE_ACCEL;
            2, 3:    type_byte = TYPE_GYRO;
            4, 5:    type_byte = TYPE_ANGLE;
            default: type_byte = BYTE_W'($urandom);
        endcase
        words = {pick_word(), pick_word(), pick_word(), pick_word()};
        if ($urandom_range(0, 7) == 0) begin
            slot = $urandom_range(0, 7);
            words[8*slot +: 8] = HEADER_BYTE;
        end
        send_frame(type_byte, words, $urandom_range(0, 4) == 0);
    endtask

    initial begin
        i_rst_n = 1'b0;
        push = 1'b0;
        i_rx_byte = '0;
        send_gaps = 1'b0;
        recv_gaps = 1'b0;
        hold_req = 1'b0;
        frames_sent = 0;
        bytes_sent = 0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed frames, with idling on both sides. Bytes other than the header are
        // dropped while hunting. The first frame carries the signed extremes, the second
        // has a bad checksum and header bytes in its data, and the last uses the header
        // value as its type, so it decodes as an unknown kind.
        send_gaps = 1'b1;
        recv_gaps = 1'b1;
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'hAA);
        send_frame(TYPE_ACCEL, {16'hFFFF, 16'h0000, 16'h8000, 16'h7FFF}, 1'b0);
        send_frame(TYPE_GYRO,  {16'h5555, 16'h8000, 16'h0001, 16'hFFFF}, 1'b1);
        send_frame(TYPE_ANGLE, {16'h0000, 16'h1234, 16'h7FFE, 16'h8001}, 1'b0);
        send_frame(HEADER_BYTE, {16'hA55A, 16'h55AA, 16'hFF00, 16'h00FF}, 1'b0);

        repeat (16) random_frame();

        // Back-pressure: the receiver holds off while the sender keeps offering bytes
        // without gaps, so both internal queues fill and full rises.
        send_gaps = 1'b0;
        recv_gaps = 1'b0;
        hold_req = 1'b1;
        repeat (10) random_frame();

        // Sender idles, receiver always ready.
        send_gaps = 1'b1;
        repeat (12) random_frame();

        // Closing stretch at full rate on both sides.
        send_gaps = 1'b0;
        repeat (13) random_frame();
        push <= 1'b0;

        while (outstanding != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d frames in %0d bytes: all kinds, signed extremes, bad checksums,",
                 frames_sent, bytes_sent);
        $display("noise, truncated frames, idling and a full stall; %0d results compared.",
                 results_checked);
        if (fail_count == 0 && outstanding == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/imu_spp_pkg.sv
rtl/imu_spp_queue.sv
rtl/imu_spp_front.sv
rtl/imu_spp_back.sv
rtl/imu_serial_packet_parser_top.sv
tb/imu_serial_packet_parser_checker.sv
tb/imu_serial_packet_parser_top_tb.sv
